FILE: rtl/spi_frame_crc8_codec_core_macros.svh
// Assertion macros for the codec checker, included by sfcc_props.sv.
`ifndef SPI_FRAME_CRC8_CODEC_CORE_MACROS_SVH
`define SPI_FRAME_CRC8_CODEC_CORE_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define SFCC_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfcc check failed");

// Next-cycle implication, off while reset is high.
`define SFCC_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfcc next-cycle check failed");

// Next-cycle implication that also runs through reset.
`define SFCC_CHECK_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sfcc reset check failed");

`endif

FILE: rtl/sfcc_pkg.sv
// Types, constants and the CRC-8 step function for the frame codec.
`timescale 1ns / 1ps
package sfcc_pkg;

  typedef enum logic {
    CMD_BUILD = 1'b0,
    CMD_CHECK = 1'b1
  } cmd_t;

  localparam logic [7:0] CRC_POLY   = 8'h2F;
  localparam logic [2:0] WRITE_TAIL = 3'b010;
  localparam logic [3:0] STEP_FULL  = 4'd8;
  localparam logic [3:0] STEP_BUILD = 4'd5;  // bits 15..11
  localparam logic [3:0] STEP_CHECK = 4'd6;  // bits 15..10

  typedef struct packed {
    cmd_t        command;
    logic [31:0] frame_word;
  } req_t;

  typedef struct packed {
    logic [31:0] out_frame;
    logic [7:0]  crc_value;
    logic        crc_match;
  } res_t;

  // Data carried between pipeline stages.
  typedef struct packed {
    cmd_t        command;
    logic [31:0] frame_word;
    logic [7:0]  crc;
  } stage_t;

  // Runs the CRC over the top nbits of bits, MSB first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                             input logic [7:0] bits,
                                             input logic [3:0] nbits);
    logic [7:0] crc;
    logic       fb;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nbits) begin
        fb  = bits[7 - i] ^ crc[7];
        crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
    end
    return crc;
  endfunction

endpackage

FILE: rtl/sfcc_crc_stage.sv
// One pipeline stage: up to eight CRC steps, then a stage register with handshake.
`timescale 1ns / 1ps
module sfcc_crc_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sfcc_pkg::stage_t in_data,
  input  logic [7:0]      step_bits,
  input  logic [3:0]      step_count,
  output logic            out_valid,
  input  logic            out_ready,
  output sfcc_pkg::stage_t out_data
);
  import sfcc_pkg::*;

  stage_t data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    data_next     = in_data;
    data_next.crc = crc8_update(in_data.crc, step_bits, step_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

FILE: rtl/spi_frame_crc8_codec_core.sv
// Top level of the frame CRC-8 codec: three CRC stages and an output register.
//
// Request channel (req_valid/req_ready/req_data): command and 32-bit frame word.
// Command build: bits 31..11 are the payload; the result frame is payload,
// CRC-8 (poly 0x2F, zero start) in bits 10..3 and 010 in bits 2..0.
// Command check: CRC over bits 31..10 is compared with bits 9..2; the frame
// is echoed and crc_match set on equality.
// Result channel (res_valid/res_ready/res_data): one result per request.
// Throughput: one request per cycle unless a res_ready stall holds the pipe;
// four register stages, each holding at most eight CRC steps or the final
// compare and format.
// Reset clears all stage valid bits; no result is pending afterward.
// A stall on res_ready holds the result and back-pressures stage by stage;
// a stage still accepts while the one after it has room, so nothing is lost
// or repeated.
`timescale 1ns / 1ps
module spi_frame_crc8_codec_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sfcc_pkg::req_t req_data,
  output logic          res_valid,
  input  logic          res_ready,
  output sfcc_pkg::res_t res_data
);
  import sfcc_pkg::*;

  stage_t s0_data, s1_data, s2_data, s3_data;
  logic   s1_valid, s2_valid, s3_valid;
  logic   s1_ready, s2_ready, s3_ready;
  logic [3:0] s3_count;
  res_t   res_next;

  always_comb begin
    s0_data.command    = req_data.command;
    s0_data.frame_word = req_data.frame_word;
    s0_data.crc        = 8'h00;
  end

  sfcc_crc_stage u_stage1 (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req_valid),
    .in_ready   (req_ready),
    .in_data    (s0_data),
    .step_bits  (s0_data.frame_word[31:24]),
    .step_count (STEP_FULL),
    .out_valid  (s1_valid),
    .out_ready  (s1_ready),
    .out_data   (s1_data)
  );

  sfcc_crc_stage u_stage2 (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s1_valid),
    .in_ready   (s1_ready),
    .in_data    (s1_data),
    .step_bits  (s1_data.frame_word[23:16]),
    .step_count (STEP_FULL),
    .out_valid  (s2_valid),
    .out_ready  (s2_ready),
    .out_data   (s2_data)
  );

  // Payload tail is one bit longer in check mode.
  assign s3_count = (s2_data.command == CMD_CHECK) ? STEP_CHECK : STEP_BUILD;

  sfcc_crc_stage u_stage3 (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s2_valid),
    .in_ready   (s2_ready),
    .in_data    (s2_data),
    .step_bits  (s2_data.frame_word[15:8]),
    .step_count (s3_count),
    .out_valid  (s3_valid),
    .out_ready  (s3_ready),
    .out_data   (s3_data)
  );

  always_comb begin
    res_next.crc_value = s3_data.crc;
    unique case (s3_data.command)
      CMD_BUILD: begin
        res_next.out_frame = {s3_data.frame_word[31:11], s3_data.crc, WRITE_TAIL};
        res_next.crc_match = 1'b0;
      end
      CMD_CHECK: begin
        res_next.out_frame = s3_data.frame_word;
        res_next.crc_match = (s3_data.frame_word[9:2] == s3_data.crc);
      end
      default: begin
        res_next.out_frame = s3_data.frame_word;
        res_next.crc_match = 1'b0;
      end
    endcase
  end

  assign s3_ready = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s3_ready) begin
      res_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && s3_ready) begin
      res_data <= res_next;
    end
  end

endmodule

FILE: rtl/sfcc_props.sv
// Port-level assertions for the codec, bound to the top level.
`timescale 1ns / 1ps
`include "spi_frame_crc8_codec_core_macros.svh"
module sfcc_props (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input sfcc_pkg::req_t req_data,
  input logic           res_valid,
  input logic           res_ready,
  input sfcc_pkg::res_t res_data
);
  import sfcc_pkg::*;

  // Stalled result holds.
  `SFCC_CHECK_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data))

  // A match flag must agree with the echoed received CRC.
  `SFCC_CHECK(a_match_crc, res_valid && res_data.crc_match,
              res_data.out_frame[9:2] == res_data.crc_value)

  // Reset leaves no result pending.
  `SFCC_CHECK_RST(a_rst_empty, rst, !res_valid)

  // An empty output register means every stage has room.
  `SFCC_CHECK(a_ready_empty, !res_valid && !rst, req_ready)

endmodule

bind spi_frame_crc8_codec_core sfcc_props u_props (.*);

FILE: verif/tb_spi_frame_crc8_codec_core.sv
// Self-checking testbench for the frame CRC-8 codec core.
`timescale 1ns / 1ps
module tb_spi_frame_crc8_codec_core;
  import sfcc_pkg::*;

  localparam logic [7:0] GEN_POLY    = 8'h2F;
  localparam logic [2:0] FRAME_TAIL  = 3'b010;
  localparam int         NUM_RANDOM  = 500;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         NUM_ROWS    = 18;

  // One row of the directed stimulus. A row with known_res set carries its
  // expected result; the others go through the predictor. seal_crc puts the
  // correct CRC into bits 9..2 before the request is sent.
  typedef struct packed {
    cmd_t        command;
    logic [31:0] word;
    logic        seal_crc;
    logic        known_res;
    res_t        res;
  } row_t;

  localparam res_t NO_RES = '0;

  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{CMD_BUILD, 32'h0000_0000, 1'b0, 1'b1, '{32'h0000_0002, 8'h00, 1'b0}},
    '{CMD_CHECK, 32'h0000_0000, 1'b0, 1'b1, '{32'h0000_0000, 8'h00, 1'b1}},
    '{CMD_BUILD, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
    '{CMD_CHECK, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
    // build ignores and replaces the low eleven bits
    '{CMD_BUILD, 32'h0000_07FF, 1'b0, 1'b1, '{32'h0000_0002, 8'h00, 1'b0}},
    // check ignores bits 1..0
    '{CMD_CHECK, 32'h0000_0003, 1'b0, 1'b1, '{32'h0000_0003, 8'h00, 1'b1}},
    '{CMD_CHECK, 32'h0000_03FC, 1'b0, 1'b1, '{32'h0000_03FC, 8'h00, 1'b0}},
    '{CMD_BUILD, 32'h8000_0000, 1'b0, 1'b0, NO_RES},
    '{CMD_CHECK, 32'h8000_0000, 1'b0, 1'b0, NO_RES},
    '{CMD_BUILD, 32'h0000_0800, 1'b0, 1'b0, NO_RES},
    '{CMD_CHECK, 32'h0000_0400, 1'b0, 1'b0, NO_RES},
    '{CMD_BUILD, 32'hAAAA_AAAA, 1'b0, 1'b0, NO_RES},
    '{CMD_BUILD, 32'h5555_5555, 1'b0, 1'b0, NO_RES},
    '{CMD_CHECK, 32'hAAAA_AAAA, 1'b0, 1'b0, NO_RES},
    '{CMD_CHECK, 32'h5555_5555, 1'b0, 1'b0, NO_RES},
    '{CMD_CHECK, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_RES},
    '{CMD_CHECK, 32'h1234_5678, 1'b1, 1'b0, NO_RES},
    '{CMD_CHECK, 32'hFFFF_FC03, 1'b0, 1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req_data;
  logic res_valid;
  logic res_ready;
  res_t res_data;

  res_t pending_results[$];
  int   mismatch_cnt = 0;
  int   cycle_cnt = 0;

  spi_frame_crc8_codec_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL spi_frame_crc8_codec_core");
      $finish;
    end
  end

  // CRC-8, zero start, over the low nbits of payload taken MSB first.
  function automatic logic [7:0] crc8_over(logic [21:0] payload, int nbits);
    logic [7:0] crc;
    logic       fb;
    crc = 8'h00;
    for (int i = nbits - 1; i >= 0; i--) begin
      fb  = payload[i] ^ crc[7];
      crc = {crc[6:0], 1'b0} ^ (fb ? GEN_POLY : 8'h00);
    end
    return crc;
  endfunction

  function automatic res_t compute_frame_result(req_t r);
    res_t       res;
    logic [7:0] crc;
    if (r.command == CMD_BUILD) begin
      crc = crc8_over({1'b0, r.frame_word[31:11]}, 21);
      res.out_frame = {r.frame_word[31:11], crc, FRAME_TAIL};
      res.crc_value = crc;
      res.crc_match = 1'b0;
    end else begin
      crc = crc8_over(r.frame_word[31:10], 22);
      res.out_frame = r.frame_word;
      res.crc_value = crc;
      res.crc_match = (r.frame_word[9:2] == crc);
    end
    return res;
  endfunction

  // Replaces bits 9..2 with the CRC a check request expects there.
  function automatic logic [31:0] seal_word(logic [31:0] word);
    return {word[31:10], crc8_over(word[31:10], 22), word[1:0]};
  endfunction

  // Wait before a request or a result; some stretches run back to back.
  function automatic int pick_wait(int seq);
    if ((seq / 48) % 4 == 3)
      return 0;
    return $urandom_range(0, 14);
  endfunction

  task automatic issue_request(req_t r, logic known, res_t known_res, int seq);
    int gap;
    gap = pick_wait(seq);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (!req_ready);
    pending_results.push_back(known ? known_res : compute_frame_result(r));
  endtask

  task automatic send_requests();
    req_t        r;
    logic [31:0] word;
    int          kind;
    for (int i = 0; i < NUM_ROWS; i++) begin
      r.command    = DIRECTED_ROWS[i].command;
      r.frame_word = DIRECTED_ROWS[i].seal_crc ? seal_word(DIRECTED_ROWS[i].word)
                                               : DIRECTED_ROWS[i].word;
      issue_request(r, DIRECTED_ROWS[i].known_res, DIRECTED_ROWS[i].res, i);
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      word = $urandom();
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        r.command    = CMD_BUILD;
        r.frame_word = word;
      end else if (kind < 8) begin
        // well-formed received frame
        r.command    = CMD_CHECK;
        r.frame_word = seal_word(word);
      end else if (kind == 8) begin
        // one bit flipped somewhere in payload or CRC
        r.command    = CMD_CHECK;
        r.frame_word = seal_word(word) ^ (32'h1 << $urandom_range(2, 31));
      end else begin
        r.command    = CMD_CHECK;
        r.frame_word = word;
      end
      issue_request(r, 1'b0, NO_RES, NUM_ROWS + i);
    end
    req_valid <= 1'b0;
  endtask

  task automatic accept_results();
    int   seq;
    int   stall;
    res_t exp_res;
    seq = 0;
    forever begin
      stall = pick_wait(seq + 24);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
      seq++;
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: frame %h crc %h match %b",
                   res_data.out_frame, res_data.crc_value, res_data.crc_match);
      end else begin
        exp_res = pending_results.pop_front();
        if (res_data.out_frame !== exp_res.out_frame ||
            res_data.crc_value !== exp_res.crc_value ||
            res_data.crc_match !== exp_res.crc_match) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result mismatch: exp frame %h crc %h match %b, got %h %h %b",
                     exp_res.out_frame, exp_res.crc_value, exp_res.crc_match,
                     res_data.out_frame, res_data.crc_value, res_data.crc_match);
        end
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req_data  <= '0;
    res_ready <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    fork
      accept_results();
    join_none
    send_requests();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("PASS spi_frame_crc8_codec_core");
    else
      $display("FAIL spi_frame_crc8_codec_core");
    $finish;
  end

endmodule
